FILE: src/ghbs_pkg.sv
`timescale 1ns / 1ps

package ghbs_pkg;

	// Defaults for the top level parameters
	localparam int DEF_GRID_DEPTH  = 4096;
	localparam int DEF_VALUE_WIDTH = 32;

	// Fixed field widths
	localparam int PTS_W     = 12;   // grid point counts
	localparam int CELL_W    = 12;   // cell index, at most 4093
	localparam int WEIGHT_W  = 17;   // Q0.16 weight, 1.0 included
	localparam int FRAC_W    = 48;   // scaled distance, Q32.16
	localparam int RAW_W     = 24;   // linear address before the wrap
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;

	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

	// Input word kinds
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// Register map
	localparam logic [CFG_IDX_W-1:0] REG_X_LIMIT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_Z_LIMIT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_X_INV    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Z_INV    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_X_POINTS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_Z_POINTS = 3'd5;

	// Cycles a query holds off the next word after its own
	localparam logic [1:0] QUERY_HOLD = 2'd3;

	// Neighbour order in a query: bit 0 steps x, bit 1 steps z
	localparam logic [1:0] NB_FIRST = 2'd0;
	localparam logic [1:0] NB_LAST  = 2'd3;

	typedef struct packed {
		logic [CELL_W-1:0]   node;
		logic [WEIGHT_W-1:0] w;
	} loc_t;

	// One access on the store port
	typedef struct packed {
		logic                vld;
		logic                wr;
		logic [1:0]          sel;
		logic [WEIGHT_W-1:0] tx;
		logic [WEIGHT_W-1:0] tz;
	} mem_op_t;

	// Cell index and weight from a scaled distance; the far edge maps to
	// the last cell with a full weight
	function automatic loc_t ghbs_locate(input logic [FRAC_W-1:0] f,
		input logic [PTS_W-1:0] pts);
		logic [PTS_W-1:0] n;
		logic [PTS_W-1:0] n_m2;
		logic [FRAC_W-1:0] cap;
		loc_t res;
		n    = (pts < 12'd2) ? 12'd2 : pts;
		n_m2 = n - 12'd2;
		cap  = FRAC_W'({n - 12'd1, 16'h0000});
		if (f >= cap) begin
			res.node = n_m2[CELL_W-1:0];
			res.w    = WEIGHT_ONE;
		end else begin
			res.node = f[16 +: CELL_W];
			res.w    = {1'b0, f[15:0]};
		end
		return res;
	endfunction

endpackage

FILE: src/grid_height_bilinear_sampler.sv
`timescale 1ns / 1ps
// A query's height appears with done from the last blend stage. Writes go
// in one per cycle while busy is low; a query holds off the next word with
// busy and reads its four neighbours one per cycle over the single store port.
// Reset clears control and the registers to their defaults; the store is not
// cleared. Results are shown for one cycle; the receiver cannot stall.
module grid_height_bilinear_sampler #(
	parameter int GRID_DEPTH  = ghbs_pkg::DEF_GRID_DEPTH,
	parameter int VALUE_WIDTH = ghbs_pkg::DEF_VALUE_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                action,
	input  logic [11:0]                         grid_index,
	input  logic signed [31:0]                  grid_value,
	input  logic signed [31:0]                  x_pos,
	input  logic signed [31:0]                  z_pos,
	output logic                                done,
	output logic signed [31:0]                  height,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ghbs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ghbs_pkg::CFG_DAT_W-1:0]      cfg_data
);
	import ghbs_pkg::*;

	localparam int AW = $clog2(GRID_DEPTH);
	localparam int EW = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;
	localparam int PW = VALUE_WIDTH + 18;
	localparam logic signed [EW-1:0] VMAX =
		{{(EW - VALUE_WIDTH + 1){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}};
	localparam logic signed [EW-1:0] VMIN =
		{{(EW - VALUE_WIDTH + 1){1'b1}}, {(VALUE_WIDTH - 1){1'b0}}};
	localparam logic signed [EW-1:0] HMAX = {{(EW - 31){1'b0}}, {31{1'b1}}};
	localparam logic signed [EW-1:0] HMIN = {{(EW - 31){1'b1}}, {31{1'b0}}};
	// Wrap by reciprocal: quotient is exact or one short
	localparam logic [RAW_W:0]   RECIP = (RAW_W + 1)'((1 << RAW_W) / GRID_DEPTH);
	localparam logic [RAW_W-1:0] DEP   = RAW_W'(GRID_DEPTH);

	// Configuration registers
	logic [30:0]      x_limit_q, z_limit_q;
	logic [31:0]      x_inv_q, z_inv_q;
	logic [PTS_W-1:0] x_points_q, z_points_q;
	logic [PTS_W-1:0] zp_w;

	logic             accept;
	logic [1:0]       busy_cnt_q;

	// Stage 1: clamp and distance, write value saturation
	logic signed [32:0] xl_s, zl_s, x_e, z_e, x_c, z_c, dx_w, dz_w;
	logic signed [EW-1:0] gv_e, gv_sat;
	logic             vld_s1, act_s1;
	logic [31:0]      dx_s1, dz_s1;
	logic [11:0]      widx_s1;
	logic [VALUE_WIDTH-1:0] wval_s1;

	// Stage 2: scale by reciprocal spacing
	logic [63:0]      px_w, pz_w;
	logic             vld_s2, act_s2;
	logic [FRAC_W-1:0] fx_s2, fz_s2;
	logic [11:0]      widx_s2;
	logic [VALUE_WIDTH-1:0] wval_s2;

	// Stage 3: cells and weights
	loc_t             lx_w, lz_w;
	logic             vld_s3, act_s3;
	logic [CELL_W-1:0] mx_s3, mz_s3;
	logic [WEIGHT_W-1:0] tx_s3, tz_s3;
	logic [11:0]      widx_s3;
	logic [VALUE_WIDTH-1:0] wval_s3;

	// Stage 4: base address
	logic [RAW_W-1:0] base_w;
	logic             vld_s4, act_s4;
	logic [RAW_W-1:0] base_s4;
	logic [WEIGHT_W-1:0] tx_s4, tz_s4;
	logic [11:0]      widx_s4;
	logic [VALUE_WIDTH-1:0] wval_s4;

	// Stage 5: neighbour sequencer
	logic             seq_act_q;
	logic [1:0]       seq_cnt_q;
	logic [RAW_W-1:0] base_q;
	logic [WEIGHT_W-1:0] tx_q, tz_q;
	mem_op_t          op_w, op_s5;
	logic [RAW_W-1:0] addr_w, addr_s5;
	logic [VALUE_WIDTH-1:0] wval_s5;

	// Stages 6 and 7: address wrap
	logic [2*RAW_W:0] red_w;
	mem_op_t          op_s6;
	logic [RAW_W-1:0] addr_s6, q_s6;
	logic [VALUE_WIDTH-1:0] wval_s6;
	logic [2*RAW_W-1:0] qd_w;
	logic [RAW_W-1:0] r_w, mod_w;
	mem_op_t          op_s7;
	logic [AW-1:0]    maddr_s7;
	logic [VALUE_WIDTH-1:0] wval_s7;

	// Store and read data
	logic signed [VALUE_WIDTH-1:0] store_q [GRID_DEPTH];
	logic signed [VALUE_WIDTH-1:0] rdata_s8;
	mem_op_t          op_s8;

	// Stages 9 to 12: blend
	logic [WEIGHT_W-1:0] w9_w, fw_w;
	logic signed [PW-1:0] prod_w, prod_s9, acc_q, rsum_w, rsh_w;
	logic             rvld_s9;
	logic [1:0]       sel_s9;
	logic [WEIGHT_W-1:0] tz_s9, tz_s10;
	logic             rowv_s10, rowlast_s10;
	logic signed [VALUE_WIDTH-1:0] row_s10;
	logic signed [PW-1:0] fprod_w, fprod_s11, facc_q, fsum_w, fsh_w;
	logic             fvld_s11, flast_s11;
	logic signed [EW-1:0] h_e, h_sat;
	logic             done_q;
	logic signed [31:0] height_q;

	// Handshake
	assign accept    = start && !busy;
	assign busy      = (busy_cnt_q != 2'd0);
	assign cfg_ready = 1'b1;
	assign zp_w      = (z_points_q < 12'd2) ? 12'd2 : z_points_q;

	// Configuration word writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_limit_q  <= '0;
			z_limit_q  <= '0;
			x_inv_q    <= 32'h0001_0000;
			z_inv_q    <= 32'h0001_0000;
			x_points_q <= 12'd2;
			z_points_q <= 12'd2;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_X_LIMIT:  x_limit_q  <= cfg_data[30:0];
				REG_Z_LIMIT:  z_limit_q  <= cfg_data[30:0];
				REG_X_INV:    x_inv_q    <= cfg_data;
				REG_Z_INV:    z_inv_q    <= cfg_data;
				REG_X_POINTS: x_points_q <= cfg_data[PTS_W-1:0];
				REG_Z_POINTS: z_points_q <= cfg_data[PTS_W-1:0];
				default: ;
			endcase
		end
	end

	// A query raises busy so that its neighbour reads own the store port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_cnt_q <= '0;
		end else if (accept && action == ACT_QUERY) begin
			busy_cnt_q <= QUERY_HOLD;
		end else if (busy_cnt_q != 2'd0) begin
			busy_cnt_q <= busy_cnt_q - 2'd1;
		end
	end

	// Clamp point to the grid and take distances from the grid origin
	assign xl_s = $signed({2'b00, x_limit_q});
	assign zl_s = $signed({2'b00, z_limit_q});
	assign x_e  = 33'(x_pos);
	assign z_e  = 33'(z_pos);
	assign gv_e = EW'(grid_value);

	always_comb begin
		if (x_e > xl_s) begin
			x_c = xl_s;
		end else if (x_e < -xl_s) begin
			x_c = -xl_s;
		end else begin
			x_c = x_e;
		end
		if (z_e > zl_s) begin
			z_c = zl_s;
		end else if (z_e < -zl_s) begin
			z_c = -zl_s;
		end else begin
			z_c = z_e;
		end
		if (gv_e > VMAX) begin
			gv_sat = VMAX;
		end else if (gv_e < VMIN) begin
			gv_sat = VMIN;
		end else begin
			gv_sat = gv_e;
		end
	end

	assign dx_w = xl_s - x_c;
	assign dz_w = z_c + zl_s;

	// Front pipeline: valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	assign px_w = 64'(dx_s1) * 64'(x_inv_q);
	assign pz_w = 64'(dz_s1) * 64'(z_inv_q);
	assign lx_w = ghbs_locate(fx_s2, x_points_q);
	assign lz_w = ghbs_locate(fz_s2, z_points_q);
	assign base_w = RAW_W'(mx_s3) * RAW_W'(zp_w) + RAW_W'(mz_s3);

	// Front pipeline: payload
	always_ff @(posedge clk) begin
		act_s1  <= action;
		dx_s1   <= dx_w[31:0];
		dz_s1   <= dz_w[31:0];
		widx_s1 <= grid_index;
		wval_s1 <= gv_sat[VALUE_WIDTH-1:0];

		act_s2  <= act_s1;
		fx_s2   <= px_w[63:16];
		fz_s2   <= pz_w[63:16];
		widx_s2 <= widx_s1;
		wval_s2 <= wval_s1;

		act_s3  <= act_s2;
		mx_s3   <= lx_w.node;
		tx_s3   <= lx_w.w;
		mz_s3   <= lz_w.node;
		tz_s3   <= lz_w.w;
		widx_s3 <= widx_s2;
		wval_s3 <= wval_s2;

		act_s4  <= act_s3;
		base_s4 <= base_w;
		tx_s4   <= tx_s3;
		tz_s4   <= tz_s3;
		widx_s4 <= widx_s3;
		wval_s4 <= wval_s3;
	end

	// Neighbour sequencer: one store access per cycle
	always_comb begin
		op_w   = '0;
		addr_w = '0;
		if (seq_act_q) begin
			op_w.vld = 1'b1;
			op_w.wr  = 1'b0;
			op_w.sel = seq_cnt_q;
			op_w.tx  = tx_q;
			op_w.tz  = tz_q;
			addr_w   = base_q + (seq_cnt_q[0] ? RAW_W'(zp_w) : '0)
				+ RAW_W'(seq_cnt_q[1]);
		end else if (vld_s4) begin
			op_w.vld = 1'b1;
			op_w.tx  = tx_s4;
			op_w.tz  = tz_s4;
			op_w.sel = NB_FIRST;
			if (act_s4 == ACT_QUERY) begin
				op_w.wr = 1'b0;
				addr_w  = base_s4;
			end else begin
				op_w.wr = 1'b1;
				addr_w  = RAW_W'(widx_s4);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_act_q <= 1'b0;
			seq_cnt_q <= '0;
		end else if (seq_act_q) begin
			seq_cnt_q <= seq_cnt_q + 2'd1;
			if (seq_cnt_q == NB_LAST) begin
				seq_act_q <= 1'b0;
			end
		end else if (vld_s4 && act_s4 == ACT_QUERY) begin
			seq_act_q <= 1'b1;
			seq_cnt_q <= 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (!seq_act_q && vld_s4) begin
			base_q <= base_s4;
			tx_q   <= tx_s4;
			tz_q   <= tz_s4;
		end
	end

	// Address wrap modulo the store depth
	assign red_w = (2*RAW_W + 1)'(addr_s5) * (2*RAW_W + 1)'(RECIP);
	assign qd_w  = (2*RAW_W)'(q_s6) * (2*RAW_W)'(DEP);
	assign r_w   = addr_s6 - qd_w[RAW_W-1:0];
	assign mod_w = (r_w >= DEP) ? r_w - DEP : r_w;

	// Store pipeline: access words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s5 <= '0;
			op_s6 <= '0;
			op_s7 <= '0;
			op_s8 <= '0;
		end else begin
			op_s5 <= op_w;
			op_s6 <= op_s5;
			op_s7 <= op_s6;
			op_s8 <= op_s7;
		end
	end

	always_ff @(posedge clk) begin
		addr_s5  <= addr_w;
		wval_s5  <= wval_s4;
		addr_s6  <= addr_s5;
		q_s6     <= red_w[2*RAW_W-1:RAW_W];
		wval_s6  <= wval_s5;
		maddr_s7 <= mod_w[AW-1:0];
		wval_s7  <= wval_s6;
	end

	// Height store, single port, in order with every access
	always_ff @(posedge clk) begin
		if (op_s7.vld && op_s7.wr) begin
			store_q[maddr_s7] <= wval_s7;
		end
		rdata_s8 <= store_q[maddr_s7];
	end

	// Weighted neighbour
	assign w9_w   = op_s8.sel[0] ? op_s8.tx : WEIGHT_ONE - op_s8.tx;
	assign prod_w = PW'(rdata_s8) * PW'($signed({1'b0, w9_w}));

	// Row sum on the second neighbour of each row
	assign rsum_w = acc_q + prod_s9;
	assign rsh_w  = rsum_w >>> 16;

	// Weighted row
	assign fw_w    = rowlast_s10 ? tz_s10 : WEIGHT_ONE - tz_s10;
	assign fprod_w = PW'(row_s10) * PW'($signed({1'b0, fw_w}));

	// Column sum and saturation
	assign fsum_w = facc_q + fprod_s11;
	assign fsh_w  = fsum_w >>> 16;
	assign h_e    = EW'($signed(fsh_w[VALUE_WIDTH-1:0]));

	always_comb begin
		if (h_e > HMAX) begin
			h_sat = HMAX;
		end else if (h_e < HMIN) begin
			h_sat = HMIN;
		end else begin
			h_sat = h_e;
		end
	end

	// Blend pipeline: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvld_s9     <= 1'b0;
			rowv_s10    <= 1'b0;
			rowlast_s10 <= 1'b0;
			fvld_s11    <= 1'b0;
			flast_s11   <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			rvld_s9     <= op_s8.vld && !op_s8.wr;
			rowv_s10    <= rvld_s9 && sel_s9[0];
			rowlast_s10 <= sel_s9[1];
			fvld_s11    <= rowv_s10;
			flast_s11   <= rowlast_s10;
			done_q      <= fvld_s11 && flast_s11;
		end
	end

	// Blend pipeline: data
	always_ff @(posedge clk) begin
		prod_s9 <= prod_w;
		sel_s9  <= op_s8.sel;
		tz_s9   <= op_s8.tz;
		if (rvld_s9 && !sel_s9[0]) begin
			acc_q <= prod_s9;
		end
		row_s10   <= $signed(rsh_w[VALUE_WIDTH-1:0]);
		tz_s10    <= tz_s9;
		fprod_s11 <= fprod_w;
		if (fvld_s11 && !flast_s11) begin
			facc_q <= fprod_s11;
		end
		if (fvld_s11 && flast_s11) begin
			height_q <= $signed(h_sat[31:0]);
		end
	end

	assign done   = done_q;
	assign height = height_q;

`ifndef ASSERT_OFF
	// New work never reaches the sequencer while it is still walking a query
	a_seq_free: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> !seq_act_q)
		else $error("sequencer overrun");

	// A taken query keeps busy high, closing the input to the next words
	a_query_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action == ACT_QUERY) |=> busy ##1 busy ##1 busy)
		else $error("query hold too short");

	// While walking, the sequencer is past the first neighbour
	a_seq_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		seq_act_q |-> (seq_cnt_q != NB_FIRST))
		else $error("sequencer count out of step");

	// Wrapped address lies inside the store
	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		op_s7.vld |-> (32'(maddr_s7) < GRID_DEPTH))
		else $error("store address out of range");
`endif

endmodule

FILE: tb/ghbs_height_checker.sv
`timescale 1ns / 1ps

// Watches the command, result and register channels of the height sampler,
// keeps its own copy of the grid and registers, and checks every height.
module ghbs_height_checker
	import ghbs_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    busy,
	input  logic                    action,
	input  logic [11:0]             grid_index,
	input  logic signed [31:0]      grid_value,
	input  logic signed [31:0]      x_pos,
	input  logic signed [31:0]      z_pos,
	input  logic                    done,
	input  logic signed [31:0]      height,
	input  logic                    cfg_valid,
	input  logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DAT_W-1:0]    cfg_data,
	output int                      fail_count,
	output int                      heights_owed,
	output int                      heights_seen
);

	localparam int STORE_DEPTH = DEF_GRID_DEPTH;
	localparam longint H_MAX = 2147483647;
	localparam longint H_MIN = -H_MAX - 1;

	// Shadow grid store and register file
	logic signed [31:0] elevation [STORE_DEPTH];
	logic [30:0]        x_lim, z_lim;
	logic [31:0]        x_inv, z_inv;
	logic [PTS_W-1:0]   x_pts, z_pts;

	logic signed [31:0] heights_due [$];
	logic signed [31:0] want_height;
	int                 errs;
	int                 seen;

	// Scaled distance to cell index and Q0.16 weight, far edge pinned
	function automatic void find_cell(input longint unsigned span, input logic [31:0] inv,
		input logic [PTS_W-1:0] pts, output int unsigned idx, output int unsigned wt);
		longint unsigned f;
		longint unsigned cap;
		int unsigned n;
		n = pts;
		if (n < 2)
			n = 2;
		f = (span * {32'd0, inv}) >> 16;
		cap = longint'(n - 1) << 16;
		if (f > cap)
			f = cap;
		idx = f >> 16;
		if (idx > n - 2)
			idx = n - 2;
		wt = f - (longint'(idx) << 16);
	endfunction

	function automatic longint grid_at(input int unsigned mz, mx, zp);
		return longint'(elevation[(mz + mx * zp) % STORE_DEPTH]);
	endfunction

	// Weighted pair, floored back to Q16.16
	function automatic longint mix(input longint a, b, input int unsigned t);
		return ((longint'(65536) - longint'(t)) * a + longint'(t) * b) >>> 16;
	endfunction

	function automatic logic signed [31:0] predict_height(input logic signed [31:0] xq, zq);
		longint x, z, xl, zl, y0, y1, h;
		int unsigned mx, mz, tx, tz, zp;
		x  = xq;
		z  = zq;
		xl = longint'(x_lim);
		zl = longint'(z_lim);
		zp = z_pts;
		if (zp < 2)
			zp = 2;
		// fold the point onto the grid extent
		if (x > xl)
			x = xl;
		if (x < -xl)
			x = -xl;
		if (z > zl)
			z = zl;
		if (z < -zl)
			z = -zl;
		find_cell(longint'(xl - x), x_inv, x_pts, mx, tx);
		find_cell(longint'(z + zl), z_inv, z_pts, mz, tz);
		y0 = mix(grid_at(mz, mx, zp), grid_at(mz, mx + 1, zp), tx);
		y1 = mix(grid_at(mz + 1, mx, zp), grid_at(mz + 1, mx + 1, zp), tx);
		h  = mix(y0, y1, tz);
		if (h > H_MAX)
			h = H_MAX;
		if (h < H_MIN)
			h = H_MIN;
		return h[31:0];
	endfunction

	// Register writes, accepted words and result words, in that order
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_lim = '0;
			z_lim = '0;
			x_inv = 32'h0001_0000;
			z_inv = 32'h0001_0000;
			x_pts = 12'd2;
			z_pts = 12'd2;
			heights_due.delete();
			errs = 0;
			seen = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_X_LIMIT:  x_lim = cfg_data[30:0];
					REG_Z_LIMIT:  z_lim = cfg_data[30:0];
					REG_X_INV:    x_inv = cfg_data;
					REG_Z_INV:    z_inv = cfg_data;
					REG_X_POINTS: x_pts = cfg_data[PTS_W-1:0];
					REG_Z_POINTS: z_pts = cfg_data[PTS_W-1:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				if (action == ACT_WRITE)
					elevation[grid_index] = grid_value;
				else
					heights_due.push_back(predict_height(x_pos, z_pos));
			end
			if (done) begin
				if (heights_due.size() == 0) begin
					errs++;
					$display("%0t: height word %0d (0x%08h) with no query waiting",
						$time, height, height);
				end else begin
					want_height = heights_due.pop_front();
					seen++;
					if (height !== want_height) begin
						errs++;
						$display("%0t: height mismatch, expected %0d (0x%08h), actual %0d (0x%08h)",
							$time, want_height, want_height, height, height);
					end
				end
			end
		end
		fail_count   <= errs;
		heights_owed <= heights_due.size();
		heights_seen <= seen;
	end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import ghbs_pkg::*;

	localparam int          RANDOM_WORDS   = 650;
	localparam int          PHASES         = 12;
	localparam int          SETTLE_CYCLES  = 24;
	localparam int unsigned CYCLE_LIMIT    = 400000;

	logic                   clk        = 1'b0;
	logic                   arst_n     = 1'b0;
	logic                   start      = 1'b0;
	logic                   busy;
	logic                   action     = ACT_WRITE;
	logic [11:0]            grid_index = '0;
	logic signed [31:0]     grid_value = '0;
	logic signed [31:0]     x_pos      = '0;
	logic signed [31:0]     z_pos      = '0;
	logic                   done;
	logic signed [31:0]     height;
	logic                   cfg_valid  = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index  = REG_X_LIMIT;
	logic [CFG_DAT_W-1:0]   cfg_data   = '0;
	int                     fail_count;
	int                     heights_owed;
	int                     heights_seen;

	int                     idle_pct   = 0;
	int                     n_writes   = 0;
	int                     n_queries  = 0;
	int                     n_settings = 0;
	int unsigned            cycles     = 0;
	logic [30:0]            aim_xl     = '0;
	logic [30:0]            aim_zl     = '0;

	grid_height_bilinear_sampler u_dut (.*);

	ghbs_height_checker u_checker (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d heights outstanding",
				cycles, heights_owed);
			$display("[grid_height_bilinear_sampler] ERROR");
			$finish;
		end
	end

	// One command word, held until the block takes it
	task automatic send_word(input logic act, input logic [11:0] idx,
		input logic signed [31:0] val, xq, zq);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		start      <= 1'b1;
		action     <= act;
		grid_index <= idx;
		grid_value <= val;
		x_pos      <= xq;
		z_pos      <= zq;
		do @(posedge clk); while (busy);
		if (act == ACT_WRITE)
			n_writes++;
		else
			n_queries++;
	endtask

	task automatic query_at(input logic signed [31:0] xq, zq);
		send_word(ACT_QUERY, 12'($urandom), 32'($urandom), xq, zq);
	endtask

	// Stop sending and let every height come out
	task automatic wait_idle();
		start <= 1'b0;
		do @(posedge clk); while (heights_owed != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic program_grid(input logic [31:0] xl, zl, xi, zi, xp, zp);
		wait_idle();
		set_register(REG_X_LIMIT, xl);
		set_register(REG_Z_LIMIT, zl);
		set_register(REG_X_INV, xi);
		set_register(REG_Z_INV, zi);
		set_register(REG_X_POINTS, xp);
		set_register(REG_Z_POINTS, zp);
		cfg_valid <= 1'b0;
		aim_xl = xl[30:0];
		aim_zl = zl[30:0];
		n_settings++;
	endtask

	// Reciprocal spacing that spreads the extent over the grid's cells
	function automatic logic [31:0] grid_inv(input logic [31:0] lim, input logic [31:0] pts);
		longint unsigned n;
		longint unsigned q;
		n = pts[11:0];
		if (n < 2)
			n = 2;
		if (lim[30:0] == 0)
			return 32'hFFFF_FFFF;
		q = ((n - 1) << 32) / (2 * longint'(lim[30:0]));
		return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
	endfunction

	// Mostly inside the extent, some on its edges, some far outside
	function automatic logic signed [31:0] aim_coord(input logic [30:0] lim);
		longint v;
		int unsigned r;
		r = $urandom_range(99);
		if (r < 65)
			v = longint'($urandom_range(2 * {1'b0, lim})) - longint'(lim);
		else if (r < 75)
			v = longint'(lim);
		else if (r < 85)
			v = -longint'(lim);
		else if (r < 95)
			v = longint'($urandom);
		else
			return r[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
		return v[31:0];
	endfunction

	initial begin
		logic [31:0] xl, zl, xi, zi, xp, zp;
		int          rnd_words;
		logic [31:0] val;
		rnd_words = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Preload every store entry so no query reads an empty one
		for (int i = 0; i < DEF_GRID_DEPTH; i++) begin
			if (i == 0)
				val = 32'h7FFF_FFFF;
			else if (i == 1)
				val = 32'h8000_0000;
			else
				val = $urandom;
			send_word(ACT_WRITE, 12'(i), val, '0, '0);
		end

		// Register defaults: zero extent, every point folds onto one spot
		idle_pct = 25;
		query_at(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		query_at(32'sh8000_0000, 32'sh8000_0000);
		query_at(32'sh0000_0000, 32'sh0000_0000);
		query_at(32'sh8000_0000, 32'sh7FFF_FFFF);

		// Small 4 x 3 grid: corners, far edge, outside points, fractions
		program_grid(32'h0003_0000, 32'h0002_0000, grid_inv(32'h0003_0000, 4),
			grid_inv(32'h0002_0000, 3), 32'd4, 32'd3);
		send_word(ACT_WRITE, 12'd0, 32'sh007B_0000, '0, '0);
		query_at(32'sh0003_0000, -32'sh0002_0000);
		query_at(-32'sh0003_0000, 32'sh0002_0000);
		query_at(32'sh0000_0000, 32'sh0000_0000);
		query_at(32'sh0004_0000, -32'sh0003_0000);
		query_at(32'sh8000_0000, 32'sh7FFF_FFFF);
		query_at(32'sh7FFF_FFFF, 32'sh8000_0000);
		query_at(32'sh0001_8000, -32'sh0000_8000);

		// Random part, one register setting per phase
		for (int p = 0; p < PHASES; p++) begin
			xp = $urandom_range(2, 12);
			zp = $urandom_range(2, 12);
			xl = $urandom_range(32'h0001_0000, 32'h0040_0000);
			zl = $urandom_range(32'h0001_0000, 32'h0040_0000);
			case (p % 8)
				// largest extent and reciprocals, longest x row
				1: begin
					xl = 32'hFFFF_FFFF;
					zl = 32'hFFFF_FFFF;
					xp = 32'd2048;
					zp = 32'd2;
				end
				// point counts below two, junk above the count field
				3: begin
					xp = ($urandom & 32'hFFFF_F000) | 32'($urandom_range(1));
					zp = ($urandom & 32'hFFFF_F000) | 32'($urandom_range(1));
				end
				// grid bigger than the store, addresses wrap
				4: begin
					xp = 32'd64;
					zp = 32'd100;
				end
				// zero extent, minimal grid
				5: begin
					xl = 32'd0;
					zl = 32'd0;
					xp = 32'd2;
					zp = 32'd2;
				end
				// longest z column over a wide extent, top bit set
				7: begin
					xl = $urandom | 32'h8000_0000;
					zl = $urandom;
					xp = 32'd2;
					zp = 32'd2048;
				end
				default: ;
			endcase
			xi = grid_inv(xl, xp);
			zi = grid_inv(zl, zp);
			case (p % 8)
				1: begin
					xi = 32'hFFFF_FFFF;
					zi = 32'hFFFF_FFFF;
				end
				// zero reciprocal on x
				2: xi = 32'd0;
				5: begin
					xi = 32'd1;
					zi = 32'd1;
				end
				// arbitrary reciprocals, sometimes zero on z
				6: begin
					xi = $urandom;
					zi = $urandom_range(1) ? 32'd0 : $urandom;
				end
				default: ;
			endcase
			program_grid(xl, zl, xi, zi, xp, zp);

			for (int k = 0; k < RANDOM_WORDS / PHASES + 1; k++) begin
				if (rnd_words < RANDOM_WORDS / 3)
					idle_pct = 25;
				else if (rnd_words < 2 * RANDOM_WORDS / 3)
					idle_pct = 72;
				else
					idle_pct = 0;
				if ($urandom_range(99) < 25) begin
					if ($urandom_range(9) == 0)
						val = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
					else
						val = $urandom;
					send_word(ACT_WRITE, 12'($urandom_range(4095)), val,
						32'($urandom), 32'($urandom));
				end else begin
					query_at(aim_coord(aim_xl), aim_coord(aim_zl));
				end
				rnd_words++;
			end
		end

		wait_idle();
		$display("Covered %0d grid writes and %0d height queries over %0d register settings,",
			n_writes, n_queries, n_settings);
		$display("with extreme extents, zero reciprocals, small counts and wrapped addresses; %0d heights compared",
			heights_seen);
		if (fail_count == 0 && heights_owed == 0) begin
			$display("[grid_height_bilinear_sampler] OK");
		end else begin
			$display("[grid_height_bilinear_sampler] ERROR");
		end
		$finish;
	end

endmodule

FILE: sim.f
src/ghbs_pkg.sv
src/grid_height_bilinear_sampler.sv
tb/ghbs_height_checker.sv
tb/testbench.sv
